// ===== sv/stfla_pkg.sv =====
// stfla_pkg: shared types and codes for the slot table allocator.
// No dependencies; used by the core, both checkers and the bench.
`timescale 1ns / 1ps
`default_nettype none

package stfla_pkg;

    // port field widths
    localparam int CMD_W  = 3;
    localparam int SLOT_W = 10;
    localparam int TAG_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 11;

    // request codes
    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REL_SLOT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REL_TAG  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REL_BASE = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_TSCAN,
        ST_BSCAN
    } state_t;

endpackage

`default_nettype wire

// ===== sv/stfla_ram.sv =====
// stfla_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/slot_table_free_list_allocator_core.sv =====
// slot_table_free_list_allocator_core: handle table with a LIFO free-slot stack.
// Depends on stfla_pkg and stfla_ram (tag table and free stack).
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  Request channel: command, slot and tag are taken at a rising edge with
//  start high and busy low. busy stays high while a request is in work.
//  Result channel: done pulses for one cycle with slot_out, tag_out, status
//  and used_count; the receiver cannot stall, so every result must be taken
//  in that cycle. done never coincides with busy: the next request can be
//  taken in the same cycle that the previous result is shown.
//  Config: base_slots_we writes base_slots; the user writes it only while the
//  block is idle, and the block itself does not enforce this.
//  Path from accept to done: add by append, add when full, out-of-range
//  get/release, bad code, and release by tag with tag zero or an empty table
//  are answered from idle; add reusing a freed slot, get and release by slot
//  do one tag/stack RAM read, then the write for add and release; release by
//  tag reads one table entry per cycle, walking down from the top and stopping
//  at the first match; release after base empties the free stack, then reads
//  one entry per cycle from base_slots up to the high-water mark, clearing and pushing each occupied one.
//  Throughput: one request at a time, bounded by the tag RAM's one read port.
//  Reset: high-water mark, free depth and base_slots go to zero. Neither RAM
//  is cleared: only entries below the high-water mark and below the free
//  depth are ever read, and those were always written first.

module slot_table_free_list_allocator_core #(
    parameter int SLOTS    = 1024,
    parameter int TAG_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [stfla_pkg::CMD_W-1:0]   command,
    input  wire logic [stfla_pkg::SLOT_W-1:0]  slot,
    input  wire logic [stfla_pkg::TAG_W-1:0]   tag,
    // result
    output logic                               done,
    output logic      [stfla_pkg::SLOT_W-1:0]  slot_out,
    output logic      [stfla_pkg::TAG_W-1:0]   tag_out,
    output logic      [stfla_pkg::STAT_W-1:0]  status,
    output logic      [stfla_pkg::CNT_W-1:0]   used_count,
    // config
    input  wire logic                          base_slots_we,
    input  wire logic [stfla_pkg::CNT_W-1:0]   base_slots
);

    import stfla_pkg::*;

    // index, count and compare widths
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > CNT_W) ? CW : CNT_W;
    // only the low TW bits of a tag (TAG_BITS, at most 32) ever reach the table
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    state_t state_reg, state_next;

    logic [CMD_W-1:0] cmd_reg;
    logic [IW-1:0]    slot_reg;
    logic [TW-1:0]    tag_reg;
    logic [CW-1:0]    hw_reg, hw_next;
    logic [CW-1:0]    fd_reg, fd_next;
    logic [CNT_W-1:0] base_reg;
    logic [XW-1:0]    scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic [IW-1:0]    pidx_reg, pidx_next;

    logic              done_reg, done_next;
    logic [IW-1:0]     sout_reg, sout_next;
    logic [TAG_W-1:0]  tout_reg, tout_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [CW-1:0]     used_reg, used_next;

    // RAM ports
    logic          t_wr_en, t_rd_en;
    logic [IW-1:0] t_wr_addr, t_rd_addr;
    logic [TW-1:0] t_wr_data, t_rd_data;
    logic          f_wr_en, f_rd_en;
    logic [IW-1:0] f_wr_addr, f_rd_addr;
    logic [IW-1:0] f_wr_data, f_rd_data;

    // shared conditions
    logic          accept;
    logic [TW-1:0] tag_in;
    logic [XW-1:0] slot_x, hw_x, base_x, scan_m1, sout_x, used_x;
    logic          in_range, fd_nz, hw_nz, hw_room, fd_room, tag_nz;
    logic          t_hit, b_more, t_more;
    logic [TAG_W-1:0] rd_tag_x;

    assign accept   = start && !busy;
    assign tag_in   = tag[TW-1:0];
    assign slot_x   = XW'(slot);
    assign hw_x     = XW'(hw_reg);
    assign base_x   = XW'(base_reg);
    assign scan_m1  = scan_reg - XW'(1);
    assign in_range = slot_x < hw_x;
    assign fd_nz    = fd_reg != '0;
    assign hw_nz    = hw_reg != '0;
    assign hw_room  = hw_reg != CW'(SLOTS);
    assign fd_room  = fd_reg != CW'(SLOTS);
    assign tag_nz   = tag_in != '0;
    assign t_hit    = pend_reg && (t_rd_data == tag_reg);
    assign t_more   = scan_reg != '0;
    assign b_more   = scan_reg < hw_x;

    always_comb
    begin
        rd_tag_x            = '0;
        rd_tag_x[TW-1:0]    = t_rd_data;
    end

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_ADD:      state_next = fd_nz ? ST_WAIT : ST_IDLE;
                        CMD_GET:      state_next = in_range ? ST_WAIT : ST_IDLE;
                        CMD_REL_SLOT: state_next = in_range ? ST_WAIT : ST_IDLE;
                        CMD_REL_TAG:  state_next = (tag_nz && hw_nz) ? ST_TSCAN : ST_IDLE;
                        CMD_REL_BASE: state_next = ST_BSCAN;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WAIT:  state_next = ST_IDLE;
            ST_TSCAN:
            begin
                if (t_hit || !t_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BSCAN:
            begin
                if (!b_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath, RAM control and result
    // ---------------------------------------------------------------
    always_comb
    begin
        hw_next   = hw_reg;
        fd_next   = fd_reg;
        scan_next = scan_reg;
        pend_next = pend_reg;
        pidx_next = pidx_reg;

        done_next = 1'b0;
        sout_next = sout_reg;
        tout_next = tout_reg;
        stat_next = stat_reg;
        used_next = used_reg;

        t_wr_en   = 1'b0;
        t_wr_addr = slot_reg;
        t_wr_data = '0;
        t_rd_en   = 1'b0;
        t_rd_addr = slot_x[IW-1:0];
        f_wr_en   = 1'b0;
        f_wr_addr = fd_reg[IW-1:0];
        f_wr_data = slot_reg;
        f_rd_en   = 1'b0;
        f_rd_addr = IW'(fd_reg - CW'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sout_next = '0;
                    tout_next = '0;
                    stat_next = STAT_OK;
                    case (command)
                        CMD_ADD:
                        begin
                            if (fd_nz)
                            begin
                                f_rd_en = 1'b1;
                            end
                            else if (hw_room)
                            begin
                                // append at the high-water mark
                                t_wr_en   = 1'b1;
                                t_wr_addr = hw_reg[IW-1:0];
                                t_wr_data = tag_in;
                                sout_next = hw_reg[IW-1:0];
                                hw_next   = hw_reg + CW'(1);
                                done_next = 1'b1;
                            end
                            else
                            begin
                                stat_next = STAT_FULL;
                                done_next = 1'b1;
                            end
                        end
                        CMD_GET, CMD_REL_SLOT:
                        begin
                            if (in_range)
                            begin
                                t_rd_en = 1'b1;
                            end
                            else
                            begin
                                stat_next = STAT_RANGE;
                                done_next = 1'b1;
                            end
                        end
                        CMD_REL_TAG:
                        begin
                            scan_next = hw_x;
                            pend_next = 1'b0;
                            if (!(tag_nz && hw_nz))
                            begin
                                stat_next = STAT_NONE;
                                done_next = 1'b1;
                            end
                        end
                        CMD_REL_BASE:
                        begin
                            fd_next   = '0;
                            scan_next = base_x;
                            pend_next = 1'b0;
                        end
                        default:
                        begin
                            stat_next = STAT_RANGE;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_WAIT:
            begin
                done_next = 1'b1;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        // reuse the most recently freed slot
                        t_wr_en   = 1'b1;
                        t_wr_addr = f_rd_data;
                        t_wr_data = tag_reg;
                        fd_next   = fd_reg - CW'(1);
                        sout_next = f_rd_data;
                    end
                    CMD_GET:
                    begin
                        tout_next = rd_tag_x;
                        stat_next = (t_rd_data == '0) ? STAT_NONE : STAT_OK;
                    end
                    CMD_REL_SLOT:
                    begin
                        if (t_rd_data == '0)
                        begin
                            stat_next = STAT_NONE;
                        end
                        else
                        begin
                            t_wr_en = 1'b1;
                            if (fd_room)
                            begin
                                f_wr_en = 1'b1;
                                fd_next = fd_reg + CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        stat_next = STAT_RANGE;
                    end
                endcase
            end

            ST_TSCAN:
            begin
                // the entry read here is compared once its registered read data returns
                if (t_hit)
                begin
                    t_wr_en   = 1'b1;
                    t_wr_addr = pidx_reg;
                    f_wr_data = pidx_reg;
                    if (fd_room)
                    begin
                        f_wr_en = 1'b1;
                        fd_next = fd_reg + CW'(1);
                    end
                    sout_next = pidx_reg;
                    stat_next = STAT_OK;
                    done_next = 1'b1;
                end
                else if (t_more)
                begin
                    t_rd_en   = 1'b1;
                    t_rd_addr = scan_m1[IW-1:0];
                    pidx_next = scan_m1[IW-1:0];
                    pend_next = 1'b1;
                    scan_next = scan_m1;
                end
                else
                begin
                    stat_next = STAT_NONE;
                    done_next = 1'b1;
                end
            end

            ST_BSCAN:
            begin
                // clear and push the entry read last cycle if occupied
                if (pend_reg && (t_rd_data != '0))
                begin
                    t_wr_en   = 1'b1;
                    t_wr_addr = pidx_reg;
                    f_wr_data = pidx_reg;
                    if (fd_room)
                    begin
                        f_wr_en = 1'b1;
                        fd_next = fd_reg + CW'(1);
                    end
                end
                if (b_more)
                begin
                    t_rd_en   = 1'b1;
                    t_rd_addr = scan_reg[IW-1:0];
                    pidx_next = scan_reg[IW-1:0];
                    pend_next = 1'b1;
                    scan_next = scan_reg + XW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    stat_next = STAT_OK;
                    done_next = 1'b1;
                end
            end

            default:
            begin
                pend_next = 1'b0;
            end
        endcase

        if (done_next)
        begin
            used_next = hw_next;
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hw_reg    <= '0;
            fd_reg    <= '0;
            base_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hw_reg    <= hw_next;
            fd_reg    <= fd_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (base_slots_we)
            begin
                base_reg <= base_slots;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            slot_reg <= slot_x[IW-1:0];
            tag_reg  <= tag_in;
        end
        scan_reg <= scan_next;
        pidx_reg <= pidx_next;
        sout_reg <= sout_next;
        tout_reg <= tout_next;
        stat_reg <= stat_next;
        used_reg <= used_next;
    end

    // ---------------------------------------------------------------
    // memories
    // ---------------------------------------------------------------
    stfla_ram #(
        .WIDTH (TW),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (t_wr_en),
        .wr_addr (t_wr_addr),
        .wr_data (t_wr_data),
        .rd_en   (t_rd_en),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data)
    );

    stfla_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_free_ram (
        .clk     (clk),
        .wr_en   (f_wr_en),
        .wr_addr (f_wr_addr),
        .wr_data (f_wr_data),
        .rd_en   (f_rd_en),
        .rd_addr (f_rd_addr),
        .rd_data (f_rd_data)
    );

    // ---------------------------------------------------------------
    // outputs
    // ---------------------------------------------------------------
    assign sout_x     = XW'(sout_reg);
    assign used_x     = XW'(used_reg);
    assign busy       = state_reg != ST_IDLE;
    assign done       = done_reg;
    assign slot_out   = sout_x[SLOT_W-1:0];
    assign tag_out    = tout_reg;
    assign status     = stat_reg;
    assign used_count = used_x[CNT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/stfla_checker.sv =====
// stfla_checker: port-level assertions for the slot table allocator core.
// Depends on stfla_pkg; bound to slot_table_free_list_allocator_core below.
`timescale 1ns / 1ps
`default_nettype none

module stfla_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [stfla_pkg::SLOT_W-1:0]  slot_out,
    input wire logic [stfla_pkg::TAG_W-1:0]   tag_out,
    input wire logic [stfla_pkg::STAT_W-1:0]  status
);

    import stfla_pkg::*;

    // a result is only shown once the core has dropped back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request either starts work or answers at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request accepted but neither busy nor answered");

    // failed requests carry no slot
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> slot_out == '0)
        else $error("slot given with failing status");

    // range errors and full never return a tag
    a_fail_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_RANGE || status == STAT_FULL)) |-> tag_out == '0)
        else $error("tag returned with range or full status");

endmodule

bind slot_table_free_list_allocator_core stfla_checker u_stfla_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .slot_out (slot_out),
    .tag_out  (tag_out),
    .status   (status)
);

`default_nettype wire

// ===== bench/slot_alloc_checker.sv =====
// slot_alloc_checker: watches the request, result and base register ports of
// the slot allocator, predicts every result and compares it. Uses stfla_pkg.
`timescale 1ns / 1ps

module slot_alloc_checker #(
    parameter int SLOTS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [stfla_pkg::CMD_W-1:0]  command,
    input  logic [stfla_pkg::SLOT_W-1:0] slot,
    input  logic [stfla_pkg::TAG_W-1:0]  tag,
    input  logic                         done,
    input  logic [stfla_pkg::SLOT_W-1:0] slot_out,
    input  logic [stfla_pkg::TAG_W-1:0]  tag_out,
    input  logic [stfla_pkg::STAT_W-1:0] status,
    input  logic [stfla_pkg::CNT_W-1:0]  used_count,
    input  logic                         base_slots_we,
    input  logic [stfla_pkg::CNT_W-1:0]  base_slots,
    output int                           mismatches,
    output int                           outstanding,
    output int                           fill_level
);

    import stfla_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_o;
        logic [TAG_W-1:0]  tag_o;
        logic [STAT_W-1:0] stat;
        logic [CNT_W-1:0]  count;
    } alloc_result_t;

    logic [TAG_W-1:0]  tag_table [SLOTS];
    logic [SLOT_W-1:0] free_list [SLOTS];
    logic [CNT_W-1:0]  fill_mark;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  keep_below;
    alloc_result_t     due_results [$];
    alloc_result_t     want;
    alloc_result_t     fresh;
    int                errors = 0;

    // empty a slot and put it on top of the free stack
    function automatic void vacate(input int s);
        tag_table[s] = '0;
        if (free_count < SLOTS)
        begin
            free_list[free_count] = SLOT_W'(s);
            free_count++;
        end
    endfunction

    function automatic alloc_result_t allocator_result(input logic [CMD_W-1:0] cmd,
                                                       input logic [SLOT_W-1:0] s,
                                                       input logic [TAG_W-1:0] t);
        alloc_result_t r;
        int            i;
        logic          hit;
        r   = '0;
        hit = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                if (free_count != 0)
                begin
                    free_count--;
                    r.slot_o = free_list[free_count];
                    tag_table[r.slot_o] = t;
                end
                else if (fill_mark < SLOTS)
                begin
                    tag_table[fill_mark] = t;
                    r.slot_o = fill_mark[SLOT_W-1:0];
                    fill_mark++;
                end
                else
                begin
                    r.stat = STAT_FULL;
                end
            end
            CMD_GET:
            begin
                if (s >= fill_mark)
                    r.stat = STAT_RANGE;
                else
                begin
                    r.tag_o = tag_table[s];
                    if (r.tag_o == '0)
                        r.stat = STAT_NONE;
                end
            end
            CMD_REL_SLOT:
            begin
                if (s >= fill_mark)
                    r.stat = STAT_RANGE;
                else if (tag_table[s] == '0)
                    r.stat = STAT_NONE;
                else
                    vacate(s);
            end
            CMD_REL_TAG:
            begin
                r.stat = STAT_NONE;
                // search downwards from the top, first match wins
                if (t != '0)
                begin
                    for (i = fill_mark; i > 0 && !hit; i--)
                    begin
                        if (tag_table[i-1] == t)
                        begin
                            vacate(i - 1);
                            r.slot_o = SLOT_W'(i - 1);
                            r.stat   = STAT_OK;
                            hit      = 1'b1;
                        end
                    end
                end
            end
            CMD_REL_BASE:
            begin
                free_count = '0;
                for (i = keep_below; i < fill_mark; i++)
                begin
                    if (tag_table[i] != '0)
                        vacate(i);
                end
            end
            default:
            begin
                r.stat = STAT_RANGE;
            end
        endcase
        r.count = fill_mark;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [TAG_W-1:0] exp_v,
                                        input logic [TAG_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_mark  = '0;
            free_count = '0;
            keep_below = '0;
            due_results.delete();
            outstanding <= 0;
            fill_level  <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // retire the older result before taking a new request
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none due, actual slot %0h tag %0h status %0h",
                             $time, slot_out, tag_out, status);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("slot_out", TAG_W'(want.slot_o), TAG_W'(slot_out));
                    check_field("tag_out", want.tag_o, tag_out);
                    check_field("status", TAG_W'(want.stat), TAG_W'(status));
                    check_field("used_count", TAG_W'(want.count), TAG_W'(used_count));
                end
            end
            if (base_slots_we)
                keep_below = base_slots;
            if (start && !busy)
            begin
                fresh       = allocator_result(command, slot, tag);
                due_results = {due_results, fresh};
            end
            outstanding <= due_results.size();
            fill_level  <= fill_mark;
            mismatches  <= errors;
        end
    end

endmodule

// ===== bench/slot_table_free_list_allocator_core_tb.sv =====
// slot_table_free_list_allocator_core_tb: request stimulus and verdict for
// the slot allocator; prediction lives in slot_alloc_checker. Uses stfla_pkg.
`timescale 1ns / 1ps

module slot_table_free_list_allocator_core_tb;
    import stfla_pkg::*;

    localparam int SLOTS          = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int END_SETTLE     = 40;

    // request codes the block does not define
    localparam logic [CMD_W-1:0] CMD_FIRST_SPARE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LAST_SPARE  = 3'd7;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic [CMD_W-1:0]  command       = '0;
    logic [SLOT_W-1:0] slot          = '0;
    logic [TAG_W-1:0]  tag           = '0;
    logic              base_slots_we = 1'b0;
    logic [CNT_W-1:0]  base_slots    = '0;

    logic              busy;
    logic              done;
    logic [SLOT_W-1:0] slot_out;
    logic [TAG_W-1:0]  tag_out;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  used_count;

    // checker outputs are registered: read at an edge they show the state
    // after the previous edge, so no race with the checker's own update
    int                mismatch_count;
    int                results_outstanding;
    int                model_fill;

    bit                gaps_on = 1'b0;
    bit                quiet_tail = 1'b0;

    always #4 clk = ~clk;

    slot_table_free_list_allocator_core #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .slot          (slot),
        .tag           (tag),
        .done          (done),
        .slot_out      (slot_out),
        .tag_out       (tag_out),
        .status        (status),
        .used_count    (used_count),
        .base_slots_we (base_slots_we),
        .base_slots    (base_slots)
    );

    slot_alloc_checker #(
        .SLOTS (SLOTS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .slot          (slot),
        .tag           (tag),
        .done          (done),
        .slot_out      (slot_out),
        .tag_out       (tag_out),
        .status        (status),
        .used_count    (used_count),
        .base_slots_we (base_slots_we),
        .base_slots    (base_slots),
        .mismatches    (mismatch_count),
        .outstanding   (results_outstanding),
        .fill_level    (model_fill)
    );

    // Present one request and hold it until the block takes it. start is
    // left high on return so that back-to-back requests need no toggling;
    // pause() or drain() lower it when a gap follows.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] s,
                         input logic [TAG_W-1:0] t);
        command <= cmd;
        slot    <= s;
        tag     <= t;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold off until every predicted result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
    endtask

    // base register write; only called with the block idle
    task automatic write_base(input logic [CNT_W-1:0] v);
        base_slots    <= v;
        base_slots_we <= 1'b1;
        @(posedge clk);
        base_slots_we <= 1'b0;
    endtask

    // Small tag alphabet so that duplicates exist and tag release hits often;
    // now and then zero, all ones or a full random word.
    function automatic logic [TAG_W-1:0] pick_tag();
        int p;
        p = $urandom_range(0, 15);
        if (p == 0)
            return '0;
        else if (p == 1)
            return '1;
        else if (p < 5)
            return TAG_W'($urandom);
        else
            return TAG_W'($urandom_range(1, 24));
    endfunction

    // Mostly slots near the used region, including one past the top;
    // sometimes any 10-bit index.
    function automatic logic [SLOT_W-1:0] pick_slot();
        int top;
        top = (model_fill < SLOTS) ? model_fill : SLOTS - 1;
        if ($urandom_range(0, 7) == 0)
            return SLOT_W'($urandom);
        else
            return SLOT_W'($urandom_range(0, top));
    endfunction

    task automatic random_request();
        int p;
        p = $urandom_range(0, 99);
        if (p < 38)
            issue(CMD_ADD, SLOT_W'($urandom), pick_tag());
        else if (p < 58)
            issue(CMD_GET, pick_slot(), TAG_W'($urandom));
        else if (p < 78)
            issue(CMD_REL_SLOT, pick_slot(), TAG_W'($urandom));
        else if (p < 93)
            issue(CMD_REL_TAG, SLOT_W'($urandom), pick_tag());
        else if (p < 96)
            issue(CMD_REL_BASE, SLOT_W'($urandom), TAG_W'($urandom));
        else
            issue(CMD_W'($urandom_range(CMD_FIRST_SPARE, CMD_LAST_SPARE)),
                  SLOT_W'($urandom), TAG_W'($urandom));
    endtask

    // Random mix; gaps switch on and off in stretches of 40 requests.
    task automatic run_mix(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                gaps_on = ($urandom_range(0, 2) != 0) && !quiet_tail;
            if (gaps_on && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 13));
            random_request();
        end
    endtask

    // Watchdog: a long run of cycles in which neither a request nor a
    // result is taken means the block has hung.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int n;
        int p;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_base('0);

        // ---- directed part, base 0 ----
        // empty table: out of range, not found or nothing to free
        issue(CMD_GET, 10'd0, '0);
        issue(CMD_REL_SLOT, 10'd1023, '1);
        issue(CMD_REL_TAG, 10'd0, '0);           // tag zero never matches
        issue(CMD_REL_TAG, 10'd0, '1);           // tag absent
        issue(CMD_REL_BASE, 10'd0, '0);          // nothing to free
        issue(CMD_FIRST_SPARE, 10'd1023, '1);
        issue(CMD_FIRST_SPARE + 3'd1, 10'd512, 32'h5555_5555);
        issue(CMD_LAST_SPARE, 10'd0, '0);
        // appends: slot 1 is given out with tag zero and stays empty
        issue(CMD_ADD, 10'd0, '1);
        issue(CMD_ADD, 10'd0, '0);
        issue(CMD_ADD, 10'd1023, 32'd1);
        issue(CMD_ADD, 10'd0, 32'd1);
        issue(CMD_GET, 10'd0, '0);
        issue(CMD_GET, 10'd1, '0);               // empty slot
        issue(CMD_GET, 10'd3, '0);
        issue(CMD_GET, 10'd4, '0);               // at the high-water mark
        issue(CMD_REL_SLOT, 10'd1, '0);          // empty slot
        issue(CMD_REL_TAG, 10'd0, 32'd1);        // duplicate: top one goes
        issue(CMD_REL_SLOT, 10'd2, '0);
        issue(CMD_ADD, 10'd0, 32'h8000_0000);    // reuses most recent free
        issue(CMD_ADD, 10'd0, 32'd5);
        issue(CMD_REL_BASE, 10'd0, '0);          // clears every occupied slot
        issue(CMD_ADD, 10'd0, 32'd7);            // highest freed slot first
        issue(CMD_GET, 10'd1023, '0);
        issue(CMD_REL_SLOT, 10'd0, '0);          // cleared by bulk release

        // ---- random phases, one base setting each ----
        // drain before every write: the base may only change while idle
        drain();
        write_base(CNT_W'($urandom_range(1, 8)));
        run_mix(170);

        drain();
        write_base(CNT_W'(SLOTS));               // above the mark: stack only
        run_mix(120);

        drain();
        write_base(CNT_W'($urandom_range(0, model_fill)));
        run_mix(120);

        drain();
        write_base('0);
        run_mix(80);

        // ---- fill up to capacity, mostly adds ----
        n = 0;
        while (model_fill < SLOTS)
        begin
            if (n % 40 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            n++;
            if (gaps_on && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 13));
            p = $urandom_range(0, 99);
            if (p < 88)
                issue(CMD_ADD, SLOT_W'($urandom), pick_tag());
            else if (p < 96)
                issue(CMD_GET, pick_slot(), TAG_W'($urandom));
            else
                issue(CMD_REL_SLOT, pick_slot(), TAG_W'($urandom));
        end

        // ---- full table, back to back with no gaps ----
        quiet_tail = 1'b1;
        gaps_on    = 1'b0;
        drain();
        write_base(CNT_W'(SLOTS));
        issue(CMD_REL_BASE, 10'd0, '0);          // empties the stack only
        issue(CMD_ADD, 10'd0, '1);               // table full
        issue(CMD_ADD, 10'd0, 32'd3);
        issue(CMD_GET, 10'd1023, '0);
        issue(CMD_REL_SLOT, 10'd1023, '0);
        issue(CMD_ADD, 10'd0, 32'hFFFF_FFFE);
        issue(CMD_GET, 10'd0, '0);
        for (n = 0; n < 3; n++)
            issue(CMD_REL_TAG, SLOT_W'($urandom), pick_tag());
        issue(CMD_REL_TAG, 10'd0, '1);

        drain();
        write_base(CNT_W'(SLOTS - 1));
        issue(CMD_REL_BASE, 10'd0, '0);          // only the last slot
        issue(CMD_ADD, 10'd0, 32'd9);

        drain();
        write_base('0);
        issue(CMD_REL_BASE, 10'd0, '0);          // walk the whole table
        issue(CMD_ADD, 10'd0, '1);
        issue(CMD_GET, 10'd1023, '0);
        run_mix(20);

        drain();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/stfla_pkg.sv
sv/stfla_ram.sv
sv/slot_table_free_list_allocator_core.sv
sv/stfla_checker.sv
bench/slot_alloc_checker.sv
bench/slot_table_free_list_allocator_core_tb.sv
